@@ hdl/mbr_pkg.sv @@
// Shared types and constants for the Mandelbrot escape-time pixel engine.
// No dependencies; used by mbr_mul, mbr_core and mandelbrot_escape_time_pixel.
package mbr_pkg;

    localparam int DATA_W   = 64;           // Q7.56 word
    localparam int FRAC_W   = 56;
    localparam int STEP_W   = 63;
    localparam int IDX_W    = 10;           // row / col
    localparam int CNT_W    = 9;            // countdown
    localparam int DEPTH_W  = 8;            // result
    localparam int PROD_W   = 2 * DATA_W;   // full product
    localparam int HALF_W   = DATA_W / 2;
    localparam int PART_W   = 2 * (HALF_W + 1);
    localparam int CFG_ADDR_W = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    localparam logic [DATA_W-1:0] FIVE_Q56       = 64'h0500_0000_0000_0000;
    localparam logic [CNT_W-1:0]  ITER_LIMIT_RST = 9'd256;
    localparam logic [CNT_W-1:0]  CNT_ALL_ONES   = 9'h1FF;

    localparam logic [CFG_ADDR_W-1:0] CFG_X_ORIGIN   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_ORIGIN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP       = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ITER_LIMIT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CX,
        ST_CY,
        ST_X2,
        ST_Y2,
        ST_XY,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

@@ hdl/mbr_mul.sv @@
// Shared signed 64x64 multiplier: four 33x33 partial products into a 128-bit accumulator.
// Depends on mbr_pkg.
module mbr_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mbr_pkg::mul_req_t             req,
    output mbr_pkg::mul_stat_t            stat,
    output logic [mbr_pkg::PROD_W-1:0]    prod
);

    logic [mbr_pkg::DATA_W-1:0] a_reg, a_next;
    logic [mbr_pkg::DATA_W-1:0] b_reg, b_next;
    logic [2:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic signed [mbr_pkg::PART_W-1:0] part_reg, part_next;
    logic [1:0]                 sh_reg, sh_next;
    logic [mbr_pkg::PROD_W-1:0] acc_reg, acc_next;

    logic signed [mbr_pkg::HALF_W:0] op_a, op_b;
    logic [mbr_pkg::PROD_W-1:0]      part_ext, addend;

    always_comb begin
        // high halves are signed, low halves unsigned
        if (cnt_reg[1]) begin
            op_a = {a_reg[mbr_pkg::DATA_W-1], a_reg[mbr_pkg::DATA_W-1:mbr_pkg::HALF_W]};
        end else begin
            op_a = {1'b0, a_reg[mbr_pkg::HALF_W-1:0]};
        end
        if (cnt_reg[0]) begin
            op_b = {b_reg[mbr_pkg::DATA_W-1], b_reg[mbr_pkg::DATA_W-1:mbr_pkg::HALF_W]};
        end else begin
            op_b = {1'b0, b_reg[mbr_pkg::HALF_W-1:0]};
        end

        part_ext = {{(mbr_pkg::PROD_W-mbr_pkg::PART_W){part_reg[mbr_pkg::PART_W-1]}},
                    part_reg};
        case (sh_reg)
            2'd0:    addend = part_ext;
            2'd1:    addend = part_ext << mbr_pkg::HALF_W;
            2'd2:    addend = part_ext << mbr_pkg::DATA_W;
            default: addend = '0;
        endcase

        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        part_next = part_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;

        if (req.start && !busy_reg) begin
            a_next    = req.a;
            b_next    = req.b;
            cnt_next  = '0;
            busy_next = 1'b1;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg != 3'd4) begin
                part_next = op_a * op_b;
                sh_next   = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != 3'd0) begin
                acc_next = acc_reg + addend;
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd4) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        part_reg <= part_next;
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("multiply request while busy");

    a_done_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> ##6 done_reg)
        else $error("product not ready six cycles after request");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && (cnt_reg == 3'd5))
        else $error("done raised mid-product");

endmodule

@@ hdl/mbr_core.sv @@
// Escape-time sequencer: forms c, then steps z = z^2 + c on the shared multiplier.
// Depends on mbr_pkg and mbr_mul.
module mbr_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mbr_pkg::IDX_W-1:0]      in_row,
    input  logic [mbr_pkg::IDX_W-1:0]      in_col,
    input  logic [mbr_pkg::DATA_W-1:0]     x_origin,
    input  logic [mbr_pkg::DATA_W-1:0]     y_origin,
    input  logic [mbr_pkg::STEP_W-1:0]     step,
    input  logic [mbr_pkg::CNT_W-1:0]      iter_limit,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic [mbr_pkg::DEPTH_W-1:0]    res_depth
);

    mbr_pkg::state_t state_reg, state_next;

    logic [mbr_pkg::IDX_W-1:0]  row_reg, row_next;
    logic [mbr_pkg::IDX_W-1:0]  col_reg, col_next;
    logic [mbr_pkg::DATA_W-1:0] cx_reg, cx_next;
    logic [mbr_pkg::DATA_W-1:0] cy_reg, cy_next;
    logic [mbr_pkg::DATA_W-1:0] x_reg, x_next;
    logic [mbr_pkg::DATA_W-1:0] y_reg, y_next;
    logic [mbr_pkg::DATA_W-1:0] x2_reg, x2_next;
    logic [mbr_pkg::DATA_W-1:0] y2_reg, y2_next;
    logic [mbr_pkg::DATA_W-1:0] xy_reg, xy_next;
    logic [mbr_pkg::CNT_W-1:0]  depth_reg, depth_next;

    mbr_pkg::mul_req_t          mul_req;
    mbr_pkg::mul_stat_t         mul_stat;
    logic [mbr_pkg::PROD_W-1:0] mul_prod;

    logic [mbr_pkg::CNT_W-1:0]  dec;
    logic [mbr_pkg::DATA_W-1:0] mag2;
    logic                       more;
    logic                       in_mul;

    mbr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .stat    (mul_stat),
        .prod    (mul_prod)
    );

    always_comb begin
        dec  = depth_reg - mbr_pkg::CNT_W'(1);
        mag2 = x2_reg + y2_reg;
        more = (dec != '0) && (dec != mbr_pkg::CNT_ALL_ONES)
            && ($signed(mag2) < $signed(mbr_pkg::FIVE_Q56));
    end

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        x2_next    = x2_reg;
        y2_next    = y2_reg;
        xy_next    = xy_reg;
        depth_next = depth_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        in_mul     = 1'b0;
        mul_req.a  = x_reg;
        mul_req.b  = x_reg;

        case (state_reg)
            mbr_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    row_next   = in_row;
                    col_next   = in_col;
                    depth_next = iter_limit;
                    state_next = mbr_pkg::ST_CX;
                end
            end
            mbr_pkg::ST_CX: begin
                in_mul    = 1'b1;
                mul_req.a = {{(mbr_pkg::DATA_W-mbr_pkg::IDX_W){1'b0}}, col_reg};
                mul_req.b = {1'b0, step};
                if (mul_stat.done) begin
                    cx_next    = x_origin - mul_prod[mbr_pkg::DATA_W-1:0];
                    x_next     = x_origin - mul_prod[mbr_pkg::DATA_W-1:0];
                    state_next = mbr_pkg::ST_CY;
                end
            end
            mbr_pkg::ST_CY: begin
                in_mul    = 1'b1;
                mul_req.a = {{(mbr_pkg::DATA_W-mbr_pkg::IDX_W){1'b0}}, row_reg};
                mul_req.b = {1'b0, step};
                if (mul_stat.done) begin
                    cy_next    = y_origin - mul_prod[mbr_pkg::DATA_W-1:0];
                    y_next     = y_origin - mul_prod[mbr_pkg::DATA_W-1:0];
                    state_next = mbr_pkg::ST_X2;
                end
            end
            mbr_pkg::ST_X2: begin
                in_mul = 1'b1;
                if (mul_stat.done) begin
                    x2_next    = mul_prod[mbr_pkg::FRAC_W +: mbr_pkg::DATA_W];
                    state_next = mbr_pkg::ST_Y2;
                end
            end
            mbr_pkg::ST_Y2: begin
                in_mul    = 1'b1;
                mul_req.a = y_reg;
                mul_req.b = y_reg;
                if (mul_stat.done) begin
                    y2_next    = mul_prod[mbr_pkg::FRAC_W +: mbr_pkg::DATA_W];
                    state_next = mbr_pkg::ST_XY;
                end
            end
            mbr_pkg::ST_XY: begin
                in_mul    = 1'b1;
                mul_req.b = y_reg;
                if (mul_stat.done) begin
                    // one fraction bit less gives 2xy
                    xy_next    = mul_prod[(mbr_pkg::FRAC_W-1) +: mbr_pkg::DATA_W];
                    state_next = mbr_pkg::ST_UPD;
                end
            end
            mbr_pkg::ST_UPD: begin
                y_next     = xy_reg + cy_reg;
                x_next     = x2_reg - y2_reg + cx_reg;
                depth_next = dec;
                state_next = more ? mbr_pkg::ST_X2 : mbr_pkg::ST_DONE;
            end
            mbr_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = mbr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mbr_pkg::ST_IDLE;
            end
        endcase

        mul_req.start = in_mul && !mul_stat.busy && !mul_stat.done;
    end

    assign res_depth = depth_reg[mbr_pkg::DEPTH_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mbr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        xy_reg    <= xy_next;
        depth_reg <= depth_next;
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> !in_ready && !res_valid)
        else $error("sequencer idle after taking a request");

    a_result_after_last_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbr_pkg::ST_UPD) && !more |=> res_valid)
        else $error("result missing after final pass");

endmodule

@@ hdl/mandelbrot_escape_time_pixel.sv @@
// Top level of the Mandelbrot escape-time pixel engine: config registers and output register.
// Depends on mbr_pkg, mbr_core and mbr_mul.
//
//   channel | direction | payload                                   | handshake
//   s_      | in        | tdata[9:0] row, [19:10] col               | tvalid/tready
//   m_      | out       | tdata[7:0] depth                          | tvalid/tready
//   cfg_    | in        | cfg_addr 0..3, cfg_wr_data (64 bits)      | cfg_wr_en
//
// Per pixel, c is formed with two products and then n passes run (at least one; at most
// iter_limit, or one if iter_limit is 0): each pass is three 64x64 products on the single
// 33x33 multiplier plus one update state.
// Reset is synchronous on aresetn; config registers return to 0, iter_limit to 256, m_tvalid to 0.
// s_tready is high only while the sequencer is idle; a result held in the output
// register under m_tready low does not stop the next request being taken.
module mandelbrot_escape_time_pixel (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mbr_pkg::S_TDATA_W-1:0]      s_tdata,     // row, col, pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mbr_pkg::M_TDATA_W-1:0]      m_tdata,     // depth
    input  logic                               cfg_wr_en,
    input  logic [mbr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mbr_pkg::DATA_W-1:0]         cfg_wr_data
);

    logic [mbr_pkg::DATA_W-1:0]  x_origin_reg;
    logic [mbr_pkg::DATA_W-1:0]  y_origin_reg;
    logic [mbr_pkg::STEP_W-1:0]  step_reg;
    logic [mbr_pkg::CNT_W-1:0]   iter_limit_reg;

    logic                        m_valid_reg, m_valid_next;
    logic [mbr_pkg::DEPTH_W-1:0] m_depth_reg, m_depth_next;

    logic                        res_valid, res_ready;
    logic [mbr_pkg::DEPTH_W-1:0] res_depth;

    mbr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_row     (s_tdata[mbr_pkg::IDX_W-1:0]),
        .in_col     (s_tdata[2*mbr_pkg::IDX_W-1:mbr_pkg::IDX_W]),
        .x_origin   (x_origin_reg),
        .y_origin   (y_origin_reg),
        .step       (step_reg),
        .iter_limit (iter_limit_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_depth  (res_depth)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg   <= '0;
            y_origin_reg   <= '0;
            step_reg       <= '0;
            iter_limit_reg <= mbr_pkg::ITER_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mbr_pkg::CFG_X_ORIGIN:   x_origin_reg   <= cfg_wr_data;
                mbr_pkg::CFG_Y_ORIGIN:   y_origin_reg   <= cfg_wr_data;
                mbr_pkg::CFG_STEP:       step_reg       <= cfg_wr_data[mbr_pkg::STEP_W-1:0];
                mbr_pkg::CFG_ITER_LIMIT: iter_limit_reg <= cfg_wr_data[mbr_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_depth_next = m_depth_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_depth_next = res_depth;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_depth_reg <= m_depth_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_depth_reg;

endmodule
